FILE: rtl/lzma_token_range_encoder_macros.svh
// Assertion macros for the LZMA token range encoder checker.
// Used by lrc_checker.sv; no other dependencies.
`ifndef LZMA_TOKEN_RANGE_ENCODER_MACROS_SVH
`define LZMA_TOKEN_RANGE_ENCODER_MACROS_SVH

// Same-cycle implication, reset-qualified.
`define LRC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, reset-qualified.
`define LRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lrc_pkg.sv
// Shared types, constants and probability address map of the LZMA range encoder.
// No dependencies; used by every module of the block except lrc_fifo.
`timescale 1ns / 1ps
`default_nettype none

package lrc_pkg;

  localparam int unsigned MAX_DIST_LOG_DEF = 23;
  localparam int unsigned TOK_QUEUE_DEPTH  = 2;
  localparam int unsigned RES_QUEUE_DEPTH  = 4;

  localparam logic [1:0] OP_LITERAL = 2'd0;
  localparam logic [1:0] OP_MATCH   = 2'd1;
  localparam logic [1:0] OP_FLUSH   = 2'd2;

  localparam int unsigned PROB_AW    = 13;
  localparam int unsigned PROB_DEPTH = 1 << PROB_AW;
  localparam logic [10:0] PROB_INIT  = 11'd1024;
  localparam logic [31:0] TOP_VALUE  = 32'h0100_0000;
  localparam logic [31:0] SHIFT_LIMIT = 32'hFF00_0000;
  localparam logic [4:0]  FLUSH_SHIFTS = 5'd5;

  // Flat map of every probability table in one memory.
  localparam logic [PROB_AW-1:0] LIT_BASE    = 13'd0;
  localparam logic [PROB_AW-1:0] MF_BASE     = 13'd6144;
  localparam logic [PROB_AW-1:0] REP_BASE    = 13'd6192;
  localparam logic [PROB_AW-1:0] SLOT_BASE   = 13'd6204;
  localparam logic [PROB_AW-1:0] FOOT_BASE   = 13'd6460;
  localparam logic [PROB_AW-1:0] ALIGN_BASE  = 13'd7100;
  localparam logic [PROB_AW-1:0] CHOICE_BASE = 13'd7116;
  localparam logic [PROB_AW-1:0] LOW_BASE    = 13'd7118;
  localparam logic [PROB_AW-1:0] MID_BASE    = 13'd7182;
  localparam logic [PROB_AW-1:0] HIGH_BASE   = 13'd7246;

  typedef enum logic [1:0] {
    KIND_LIT   = 2'd0,
    KIND_MATCH = 2'd1,
    KIND_FLUSH = 2'd2
  } tok_kind_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  literal_byte;
    logic [7:0]  prev_byte;
    logic [7:0]  match_byte;
    logic [8:0]  match_length;
    logic [23:0] match_distance;
  } tok_in_t;

  typedef struct packed {
    logic [7:0]  first_byte;
    logic [7:0]  fill_byte;
    logic [31:0] fill_count;
    logic        last;
  } res_t;

  // Classified token handed from front to back.
  typedef struct packed {
    tok_kind_e          kind;
    logic [7:0]         sym;
    logic [7:0]         mbyte;
    logic               matched;
    logic [PROB_AW-1:0] lit_base;
    logic [5:0]         mf_idx;
    logic [3:0]         tstate;
    logic               c0;
    logic               c1;
    logic [PROB_AW-1:0] len_base;
    logic [4:0]         len_nbits;
    logic [7:0]         len_val;
    logic [1:0]         lstate;
    logic [5:0]         slot;
    logic [4:0]         fb;
    logic [23:0]        dv;
  } desc_t;

endpackage

`default_nettype wire

FILE: rtl/lzma_token_range_encoder.sv
// Top level of the LZMA token range encoder (lc=3, lp=0, pb=2).
// Depends on lrc_pkg, lrc_front, lrc_fifo and lrc_back.
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake           Transfer when
// token    in         push_i / full_o     push_i && !full_o
// result   out        pop_i / empty_o     pop_i && !empty_o
//
// Each coded bit steps through ST_BIT, ST_MUL and ST_UPD (memory read,
// multiply, range update); a direct bit skips ST_MUL. A bit that drops the
// range below 2^24 then normalizes in ST_NORM, shifting one byte out at a
// time until the range is back at or above 2^24.
// The front locates the distance slot of each match by scanning down from
// the top distance bit.
// After reset, a clearing pass writes all 8192 probabilities to 1024
// before the first token is coded; tokens are queued meanwhile.
// A full result queue stalls the coder at its next byte emission.

module lzma_token_range_encoder #(
  parameter int unsigned MAX_DISTANCE_LOG = lrc_pkg::MAX_DIST_LOG_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  lrc_pkg::tok_in_t token_i,
  output logic             full_o,
  output logic             empty_o,
  input  logic             pop_i,
  output lrc_pkg::res_t    result_o
);
  import lrc_pkg::*;

  // Front to token queue.
  logic  fq_push, fq_full;
  desc_t fq_desc;

  // Token queue to back.
  logic  tq_empty, tq_pop;
  desc_t tq_desc;

  // Back to result queue.
  logic  rq_push, rq_full;
  res_t  rq_data;

  // Classify and hold token state; matches wait here while the slot is found.
  lrc_front #(
    .MAX_DISTANCE_LOG(MAX_DISTANCE_LOG)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push_i),
    .token_i  (token_i),
    .full_o   (full_o),
    .q_push_o (fq_push),
    .q_desc_o (fq_desc),
    .q_full_i (fq_full)
  );

  // Decouple front and back so either side can stall on its own.
  lrc_fifo #(
    .WIDTH($bits(desc_t)),
    .DEPTH(TOK_QUEUE_DEPTH)
  ) u_tok_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_push),
    .data_i  (fq_desc),
    .full_o  (fq_full),
    .pop_i   (tq_pop),
    .data_o  (tq_desc),
    .empty_o (tq_empty)
  );

  // Range-code the token bit by bit and shift bytes out.
  lrc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tq_empty_i (tq_empty),
    .tq_desc_i  (tq_desc),
    .tq_pop_o   (tq_pop),
    .res_full_i (rq_full),
    .res_push_o (rq_push),
    .res_data_o (rq_data)
  );

  // Hold finished results until the consumer pops them.
  lrc_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(RES_QUEUE_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rq_push),
    .data_i  (rq_data),
    .full_o  (rq_full),
    .pop_i   (pop_i),
    .data_o  (result_o),
    .empty_o (empty_o)
  );

endmodule

`default_nettype wire

FILE: rtl/lrc_fifo.sv
// Small register-based FIFO used for the token queue and the result queue.
// No package dependency.
`timescale 1ns / 1ps
`default_nettype none

module lrc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q, rptr_q;
  logic [AW:0]      cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      cnt_q <= cnt_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lrc_front.sv
// Front end: accepts tokens, tracks token state and position, classifies matches.
// Depends on lrc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lrc_front #(
  parameter int unsigned MAX_DISTANCE_LOG = lrc_pkg::MAX_DIST_LOG_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  lrc_pkg::tok_in_t token_i,
  output logic            full_o,
  output logic            q_push_o,
  output lrc_pkg::desc_t  q_desc_o,
  input  logic            q_full_i
);
  import lrc_pkg::*;

  localparam longint unsigned DMAX = 64'd1 << MAX_DISTANCE_LOG;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_SCAN = 3'b010,
    F_PUSH = 3'b100
  } fstate_e;

  fstate_e     state_q, state_d;
  logic [3:0]  ts_q, ts_d;
  logic [1:0]  pos_q, pos_d;
  desc_t       desc_q, desc_d;
  logic [23:0] dsym_q, dsym_d;
  logic [4:0]  idx_q, idx_d;

  logic [8:0]  len_c, ls;
  logic [23:0] dist_c;
  logic [4:0]  fb_c;

  assign full_o   = (state_q != F_IDLE);
  assign q_push_o = (state_q == F_PUSH);
  assign q_desc_o = desc_q;

  always_comb begin
    state_d = state_q;
    ts_d    = ts_q;
    pos_d   = pos_q;
    desc_d  = desc_q;
    dsym_d  = dsym_q;
    idx_d   = idx_q;
    fb_c    = idx_q - 5'd1;

    // Clamp length and distance into their legal ranges.
    len_c = token_i.match_length;
    if (len_c < 9'd2) len_c = 9'd2;
    if (len_c > 9'd273) len_c = 9'd273;
    ls = len_c - 9'd2;
    dist_c = token_i.match_distance;
    if (dist_c == '0) dist_c = 24'd1;
    if (64'(dist_c) > DMAX) dist_c = 24'(DMAX);

    case (state_q)
      F_IDLE: begin
        if (push_i) begin
          desc_d.sym      = token_i.literal_byte;
          desc_d.mbyte    = token_i.match_byte;
          desc_d.matched  = (ts_q >= 4'd7);
          desc_d.lit_base = LIT_BASE
                          + 13'({token_i.prev_byte[7:5], 9'b0})
                          + 13'({token_i.prev_byte[7:5], 8'b0});
          desc_d.mf_idx   = {ts_q, pos_q};
          desc_d.tstate   = ts_q;
          case (token_i.opcode)
            OP_LITERAL: begin
              desc_d.kind = KIND_LIT;
              if (ts_q < 4'd4)       ts_d = 4'd0;
              else if (ts_q < 4'd10) ts_d = ts_q - 4'd3;
              else                   ts_d = ts_q - 4'd6;
              pos_d   = pos_q + 2'd1;
              state_d = F_PUSH;
            end
            OP_MATCH: begin
              desc_d.kind = KIND_MATCH;
              desc_d.c0   = (ls >= 9'd8);
              desc_d.c1   = (ls >= 9'd16);
              if (ls < 9'd8) begin
                desc_d.len_base  = LOW_BASE + 13'({pos_q, 4'b0});
                desc_d.len_nbits = 5'd3;
                desc_d.len_val   = {5'b0, ls[2:0]};
              end else if (ls < 9'd16) begin
                desc_d.len_base  = MID_BASE + 13'({pos_q, 4'b0});
                desc_d.len_nbits = 5'd3;
                desc_d.len_val   = {5'b0, ls[2:0]};
              end else begin
                desc_d.len_base  = HIGH_BASE;
                desc_d.len_nbits = 5'd8;
                desc_d.len_val   = 8'(ls - 9'd16);
              end
              desc_d.lstate = (ls < 9'd3) ? ls[1:0] : 2'd3;
              ts_d    = (ts_q < 4'd7) ? 4'd7 : 4'd10;
              pos_d   = pos_q + len_c[1:0];
              dsym_d  = dist_c - 24'd1;
              idx_d   = 5'd23;
              state_d = F_SCAN;
            end
            OP_FLUSH: begin
              desc_d.kind = KIND_FLUSH;
              state_d     = F_PUSH;
            end
            default: begin
              // Unused opcode: drop it.
            end
          endcase
        end
      end
      F_SCAN: begin
        // Walk down from the top bit to find the distance slot.
        if (dsym_q[idx_q] || idx_q <= 5'd1) begin
          if (idx_q >= 5'd2) begin
            desc_d.slot = {idx_q, dsym_q[fb_c]};
            desc_d.fb   = fb_c;
            desc_d.dv   = dsym_q & ((24'd1 << fb_c) - 24'd1);
          end else begin
            desc_d.slot = {4'b0, dsym_q[1:0]};
            desc_d.fb   = '0;
            desc_d.dv   = '0;
          end
          state_d = F_PUSH;
        end else begin
          idx_d = idx_q - 5'd1;
        end
      end
      F_PUSH: begin
        if (!q_full_i) state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      ts_q    <= '0;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      ts_q    <= ts_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    desc_q <= desc_d;
    dsym_q <= dsym_d;
    idx_q  <= idx_d;
  end

endmodule

`default_nettype wire

FILE: rtl/lrc_back.sv
// Back end: bit sequencer, probability memory, range coder and byte shifter.
// Depends on lrc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lrc_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           tq_empty_i,
  input  lrc_pkg::desc_t tq_desc_i,
  output logic           tq_pop_o,
  input  logic           res_full_i,
  output logic           res_push_o,
  output lrc_pkg::res_t  res_data_o
);
  import lrc_pkg::*;

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_BIT   = 8'b0000_0100,
    ST_MUL   = 8'b0000_1000,
    ST_UPD   = 8'b0001_0000,
    ST_NORM  = 8'b0010_0000,
    ST_FLUSH = 8'b0100_0000,
    ST_END   = 8'b1000_0000
  } bstate_e;

  typedef enum logic [9:0] {
    PH_MATCHFLAG = 10'b00_0000_0001,
    PH_LIT       = 10'b00_0000_0010,
    PH_REP       = 10'b00_0000_0100,
    PH_CHOICE0   = 10'b00_0000_1000,
    PH_CHOICE1   = 10'b00_0001_0000,
    PH_LEN       = 10'b00_0010_0000,
    PH_SLOT      = 10'b00_0100_0000,
    PH_FOOT      = 10'b00_1000_0000,
    PH_DIRECT    = 10'b01_0000_0000,
    PH_ALIGN     = 10'b10_0000_0000
  } phase_e;

  function automatic logic [23:0] align_left(logic [23:0] v, logic [4:0] n);
    return v << (5'd24 - n);
  endfunction

  logic [10:0] prob_mem [PROB_DEPTH];
  logic [10:0] rdata_q;

  bstate_e            state_q, state_d;
  phase_e             phase_q, phase_d;
  desc_t              desc_q, desc_d;
  logic [32:0]        low_q, low_d;
  logic [31:0]        range_q, range_d;
  logic [7:0]         cached_q, cached_d;
  logic [31:0]        pend_q, pend_d;
  logic [PROB_AW-1:0] addr_q, addr_d;
  logic               bit_q, bit_d;
  logic               direct_q, direct_d;
  logic [31:0]        bound_q, bound_d;
  logic [7:0]         m_q, m_d;
  logic [4:0]         cnt_q, cnt_d;
  logic [23:0]        val_q, val_d;
  logic               rev_q, rev_d;
  logic [PROB_AW-1:0] tbase_q, tbase_d;
  logic [7:0]         sym_q, sym_d;
  logic [7:0]         mb_q, mb_d;
  logic               matched_q, matched_d;
  res_t               hold_q, hold_d;
  logic               hold_valid_q, hold_valid_d;
  logic [PROB_AW-1:0] clr_q, clr_d;

  logic [PROB_AW-1:0] cur_addr, mem_waddr;
  logic               cur_bit, cur_direct, mem_we, adv, do_shift, stall;
  logic [10:0]        prob_new, mem_wdata;
  logic               sh_emit, sh_carry;
  res_t               sh_item;
  logic [31:0]        rn;
  logic [32:0]        ln;

  // Address and value of the bit the sequencer is on.
  always_comb begin
    cur_addr   = tbase_q + 13'(m_q);
    cur_bit    = rev_q ? val_q[0] : val_q[23];
    cur_direct = 1'b0;
    case (phase_q)
      PH_MATCHFLAG: begin
        cur_addr = MF_BASE + 13'(desc_q.mf_idx);
        cur_bit  = (desc_q.kind == KIND_MATCH);
      end
      PH_LIT: begin
        cur_addr = desc_q.lit_base + 13'(m_q)
                 + (matched_q ? (13'h100 + 13'({mb_q[7], 8'h00})) : 13'h0);
        cur_bit  = sym_q[7];
      end
      PH_REP: begin
        cur_addr = REP_BASE + 13'(desc_q.tstate);
        cur_bit  = 1'b0;
      end
      PH_CHOICE0: begin
        cur_addr = CHOICE_BASE;
        cur_bit  = desc_q.c0;
      end
      PH_CHOICE1: begin
        cur_addr = CHOICE_BASE + 13'd1;
        cur_bit  = desc_q.c1;
      end
      PH_DIRECT: begin
        cur_direct = 1'b1;
        cur_bit    = val_q[23];
      end
      default: begin
      end
    endcase
  end

  // One byte shift of the coder, with carry into the cached byte.
  always_comb begin
    sh_carry            = low_q[32];
    sh_emit             = (low_q[31:0] < SHIFT_LIMIT) || sh_carry;
    sh_item.first_byte  = cached_q + 8'(sh_carry);
    sh_item.fill_byte   = 8'hFF + 8'(sh_carry);
    sh_item.fill_count  = pend_q - 32'd1;
    sh_item.last        = 1'b0;
    stall               = sh_emit && hold_valid_q && res_full_i;
  end

  assign prob_new = bit_q ? (rdata_q - (rdata_q >> 5))
                          : (rdata_q + 11'((12'd2048 - 12'(rdata_q)) >> 5));

  always_comb begin
    state_d      = state_q;
    phase_d      = phase_q;
    desc_d       = desc_q;
    low_d        = low_q;
    range_d      = range_q;
    cached_d     = cached_q;
    pend_d       = pend_q;
    addr_d       = addr_q;
    bit_d        = bit_q;
    direct_d     = direct_q;
    bound_d      = bound_q;
    m_d          = m_q;
    cnt_d        = cnt_q;
    val_d        = val_q;
    rev_d        = rev_q;
    tbase_d      = tbase_q;
    sym_d        = sym_q;
    mb_d         = mb_q;
    matched_d    = matched_q;
    hold_d       = hold_q;
    hold_valid_d = hold_valid_q;
    clr_d        = clr_q;
    tq_pop_o     = 1'b0;
    res_push_o   = 1'b0;
    res_data_o   = hold_q;
    mem_we       = 1'b0;
    mem_waddr    = addr_q;
    mem_wdata    = prob_new;
    adv          = 1'b0;
    do_shift     = 1'b0;
    rn           = range_q;
    ln           = low_q;

    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = PROB_INIT;
        clr_d     = clr_q + 1'b1;
        if (clr_q == '1) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (!tq_empty_i) begin
          tq_pop_o = 1'b1;
          desc_d   = tq_desc_i;
          if (tq_desc_i.kind == KIND_FLUSH) begin
            cnt_d   = FLUSH_SHIFTS;
            state_d = ST_FLUSH;
          end else begin
            phase_d = PH_MATCHFLAG;
            cnt_d   = 5'd1;
            state_d = ST_BIT;
          end
        end
      end
      ST_BIT: begin
        addr_d   = cur_addr;
        bit_d    = cur_bit;
        direct_d = cur_direct;
        state_d  = cur_direct ? ST_UPD : ST_MUL;
      end
      ST_MUL: begin
        bound_d = {11'b0, range_q[31:11]} * {21'b0, rdata_q};
        mem_we  = 1'b1;
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (direct_q) begin
          rn = range_q >> 1;
          ln = low_q + (bit_q ? {1'b0, rn} : 33'd0);
        end else if (bit_q) begin
          rn = range_q - bound_q;
          ln = low_q + {1'b0, bound_q};
        end else begin
          rn = bound_q;
        end
        range_d = rn;
        low_d   = ln;
        if (rn < TOP_VALUE) state_d = ST_NORM;
        else adv = 1'b1;
      end
      ST_NORM: begin
        if (range_q < TOP_VALUE) begin
          if (!stall) begin
            do_shift = 1'b1;
            range_d  = range_q << 8;
          end
        end else begin
          adv = 1'b1;
        end
      end
      ST_FLUSH: begin
        if (!stall) begin
          do_shift = 1'b1;
          cnt_d    = cnt_q - 5'd1;
          if (cnt_q == 5'd1) state_d = ST_END;
        end
      end
      ST_END: begin
        // Release the held emission as the last one of this token.
        if (hold_valid_q) begin
          if (!res_full_i) begin
            res_push_o      = 1'b1;
            res_data_o      = hold_q;
            res_data_o.last = 1'b1;
            hold_valid_d    = 1'b0;
            state_d         = ST_IDLE;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (do_shift) begin
      if (sh_emit) begin
        if (hold_valid_q) begin
          res_push_o = 1'b1;
          res_data_o = hold_q;
        end
        hold_d       = sh_item;
        hold_valid_d = 1'b1;
        cached_d     = low_q[31:24];
        pend_d       = 32'd1;
      end else begin
        pend_d = pend_q + 32'd1;
      end
      low_d = {1'b0, low_q[23:0], 8'h00};
    end

    // Step the sequencer to the next coded bit.
    if (adv) begin
      m_d       = {m_q[6:0], bit_q};
      cnt_d     = cnt_q - 5'd1;
      val_d     = rev_q ? (val_q >> 1) : (val_q << 1);
      sym_d     = sym_q << 1;
      mb_d      = mb_q << 1;
      matched_d = matched_q && (mb_q[7] == bit_q);
      state_d   = ST_BIT;
      if (cnt_q == 5'd1) begin
        case (phase_q)
          PH_MATCHFLAG: begin
            if (desc_q.kind == KIND_MATCH) begin
              phase_d = PH_REP;
              cnt_d   = 5'd1;
            end else begin
              phase_d   = PH_LIT;
              cnt_d     = 5'd8;
              m_d       = 8'd1;
              sym_d     = desc_q.sym;
              mb_d      = desc_q.mbyte;
              matched_d = desc_q.matched;
            end
          end
          PH_REP: begin
            phase_d = PH_CHOICE0;
            cnt_d   = 5'd1;
          end
          PH_CHOICE0, PH_CHOICE1: begin
            if (phase_q == PH_CHOICE0 && desc_q.c0) begin
              phase_d = PH_CHOICE1;
              cnt_d   = 5'd1;
            end else begin
              phase_d = PH_LEN;
              tbase_d = desc_q.len_base;
              cnt_d   = desc_q.len_nbits;
              m_d     = 8'd1;
              rev_d   = 1'b0;
              val_d   = align_left({16'b0, desc_q.len_val}, desc_q.len_nbits);
            end
          end
          PH_LEN: begin
            phase_d = PH_SLOT;
            tbase_d = SLOT_BASE + 13'({desc_q.lstate, 6'b0});
            cnt_d   = 5'd6;
            m_d     = 8'd1;
            rev_d   = 1'b0;
            val_d   = align_left({18'b0, desc_q.slot}, 5'd6);
          end
          PH_SLOT: begin
            m_d = 8'd1;
            if (desc_q.slot < 6'd4) begin
              state_d = ST_END;
            end else if (desc_q.slot < 6'd14) begin
              phase_d = PH_FOOT;
              tbase_d = FOOT_BASE + 13'({desc_q.slot - 6'd4, 6'b0});
              cnt_d   = desc_q.fb;
              rev_d   = 1'b1;
              val_d   = desc_q.dv;
            end else begin
              phase_d = PH_DIRECT;
              cnt_d   = desc_q.fb - 5'd4;
              rev_d   = 1'b0;
              val_d   = align_left(desc_q.dv >> 4, desc_q.fb - 5'd4);
            end
          end
          PH_DIRECT: begin
            phase_d = PH_ALIGN;
            tbase_d = ALIGN_BASE;
            cnt_d   = 5'd4;
            m_d     = 8'd1;
            rev_d   = 1'b1;
            val_d   = {20'b0, desc_q.dv[3:0]};
          end
          default: state_d = ST_END;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      prob_mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= prob_mem[cur_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      phase_q      <= PH_MATCHFLAG;
      low_q        <= '0;
      range_q      <= 32'hFFFF_FFFF;
      cached_q     <= '0;
      pend_q       <= 32'd1;
      cnt_q        <= '0;
      hold_valid_q <= 1'b0;
      clr_q        <= '0;
    end else begin
      state_q      <= state_d;
      phase_q      <= phase_d;
      low_q        <= low_d;
      range_q      <= range_d;
      cached_q     <= cached_d;
      pend_q       <= pend_d;
      cnt_q        <= cnt_d;
      hold_valid_q <= hold_valid_d;
      clr_q        <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    desc_q    <= desc_d;
    addr_q    <= addr_d;
    bit_q     <= bit_d;
    direct_q  <= direct_d;
    bound_q   <= bound_d;
    m_q       <= m_d;
    val_q     <= val_d;
    rev_q     <= rev_d;
    tbase_q   <= tbase_d;
    sym_q     <= sym_d;
    mb_q      <= mb_d;
    matched_q <= matched_d;
    hold_q    <= hold_d;
  end

endmodule

`default_nettype wire

FILE: rtl/lrc_checker.sv
// Port-level checker for the LZMA token range encoder, bound to the top level.
// Depends on lrc_pkg and lzma_token_range_encoder_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "lzma_token_range_encoder_macros.svh"

module lrc_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             push_i,
  input lrc_pkg::tok_in_t token_i,
  input logic             full_o,
  input logic             empty_o,
  input logic             pop_i,
  input lrc_pkg::res_t    result_o
);

  // Front is busy in the cycle after taking a token it keeps.
  `LRC_ASSERT_NEXT(a_busy_after_transfer, push_i && !full_o && token_i.opcode <= lrc_pkg::OP_FLUSH, full_o, "front idle")

  // Fill bytes are 0xFF, or 0x00 after a carry.
  `LRC_ASSERT_NOW(a_fill_value, !empty_o, (&result_o.fill_byte) || !(|result_o.fill_byte), "bad fill")

  // A waiting result stays put until popped.
  `LRC_ASSERT_NEXT(a_result_hold, !empty_o && !pop_i, !empty_o && $stable(result_o), "result moved")

endmodule

bind lzma_token_range_encoder lrc_checker u_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .push_i   (push_i),
  .token_i  (token_i),
  .full_o   (full_o),
  .empty_o  (empty_o),
  .pop_i    (pop_i),
  .result_o (result_o)
);

`default_nettype wire

FILE: bench/lzma_token_range_encoder_tb.sv
// Self-checking testbench for lzma_token_range_encoder: drives tokens, predicts
// every coder byte emission and checks the results in order.
// Depends on lrc_pkg and the RTL of the block.
`timescale 1ns / 1ps
`default_nettype none

// Scoreboard: a bit-exact LZMA range coder that turns each accepted token into
// the byte emissions it causes, and a queue of those emissions awaiting the DUT.
class lzma_emission_sb;
  localparam int MF_OFS     = 6144;
  localparam int REP_OFS    = 6192;
  localparam int SLOT_OFS   = 6204;
  localparam int FOOT_OFS   = 6460;
  localparam int ALIGN_OFS  = 7100;
  localparam int CHOICE_OFS = 7116;
  localparam int LOWLEN_OFS = 7118;
  localparam int MIDLEN_OFS = 7182;
  localparam int HILEN_OFS  = 7246;

  bit [10:0]         prob [8192];
  longint unsigned   low;
  bit [31:0]         rng;
  bit [7:0]          cache;
  bit [31:0]         pend;
  int unsigned       tstate;
  int unsigned       pos;
  lrc_pkg::res_t     pending_emissions [$];
  int                mismatches;

  function new();
    foreach (prob[i]) prob[i] = 11'd1024;
    low = 0;
    rng = 32'hFFFF_FFFF;
    cache = 8'd0;
    pend = 32'd1;
    tstate = 0;
    pos = 0;
    mismatches = 0;
  endfunction

  function void shift_byte();
    bit [31:0]     low32;
    bit            carry;
    lrc_pkg::res_t r;
    low32 = low[31:0];
    carry = low[32];
    if (low32 < 32'hFF00_0000 || carry) begin
      r.first_byte = cache + carry;
      r.fill_byte  = 8'hFF + carry;
      r.fill_count = pend - 1;
      r.last       = 1'b0;
      pending_emissions.insert(pending_emissions.size(), r);
      pend  = 0;
      cache = low32[31:24];
    end
    pend = pend + 1;
    low  = {low32[23:0], 8'h00};
  endfunction

  function void normalize();
    while (rng < 32'h0100_0000) begin
      rng = rng << 8;
      shift_byte();
    end
  endfunction

  function void code_bit(int idx, bit b);
    bit [31:0] pr;
    bit [31:0] bound;
    pr = prob[idx];
    bound = (rng >> 11) * pr;
    if (!b) begin
      rng = bound;
      pr = pr + ((32'd2048 - pr) >> 5);
    end else begin
      low = low + bound;
      rng = rng - bound;
      pr = pr - (pr >> 5);
    end
    prob[idx] = pr[10:0];
    normalize();
  endfunction

  function void code_direct(bit [31:0] v, int nbits);
    for (int i = nbits - 1; i >= 0; i--) begin
      rng = rng >> 1;
      if (v[i]) low = low + rng;
      normalize();
    end
  endfunction

  function void code_tree(int base, int nbits, bit [31:0] sym);
    int m;
    m = 1;
    for (int i = nbits - 1; i >= 0; i--) begin
      code_bit(base + m, sym[i]);
      m = (m << 1) | sym[i];
    end
  endfunction

  function void code_rtree(int base, int nbits, bit [31:0] sym);
    int m;
    m = 1;
    for (int i = 0; i < nbits; i++) begin
      code_bit(base + m, sym[i]);
      m = (m << 1) | sym[i];
    end
  endfunction

  function void code_literal(bit [7:0] sym, bit [7:0] mbyte, bit [7:0] prev);
    int base;
    int m;
    int i;
    base = (prev >> 5) * 'h300;
    m = 1;
    i = 7;
    // After a match, code bits against the match byte until the first mismatch.
    if (tstate >= 7) begin
      while (i >= 0) begin
        code_bit(base + 'h100 + (mbyte[i] << 8) + m, sym[i]);
        m = (m << 1) | sym[i];
        i--;
        if (mbyte[i+1] != sym[i+1]) break;
      end
    end
    for (; i >= 0; i--) begin
      code_bit(base + m, sym[i]);
      m = (m << 1) | sym[i];
    end
  endfunction

  function int unsigned slot_of(bit [31:0] v);
    int unsigned n;
    bit [31:0] t;
    if (v < 4) return v;
    n = 0;
    t = v;
    while (t >= 2) begin
      t = t >> 1;
      n++;
    end
    return (n << 1) | v[n-1];
  endfunction

  function void code_match(int unsigned len, bit [31:0] distance, int unsigned ps);
    int unsigned ls;
    bit [31:0]   dsym;
    int unsigned slot;
    int unsigned lst;
    int          fb;
    bit [31:0]   dv;
    ls = len - 2;
    dsym = distance - 1;
    slot = slot_of(dsym);
    lst = (ls < 3) ? ls : 3;
    code_bit(MF_OFS + tstate * 4 + ps, 1'b1);
    code_bit(REP_OFS + tstate, 1'b0);
    if (ls < 8) begin
      code_bit(CHOICE_OFS, 1'b0);
      code_tree(LOWLEN_OFS + ps * 16, 3, ls);
    end else if (ls < 16) begin
      code_bit(CHOICE_OFS, 1'b1);
      code_bit(CHOICE_OFS + 1, 1'b0);
      code_tree(MIDLEN_OFS + ps * 16, 3, ls - 8);
    end else begin
      code_bit(CHOICE_OFS, 1'b1);
      code_bit(CHOICE_OFS + 1, 1'b1);
      code_tree(HILEN_OFS, 8, ls - 16);
    end
    code_tree(SLOT_OFS + lst * 64, 6, slot);
    if (slot >= 4) begin
      fb = (slot >> 1) - 1;
      dv = dsym - ((2 | (slot & 1)) << fb);
      if (slot < 14) begin
        code_rtree(FOOT_OFS + (slot - 4) * 64, fb, dv);
      end else begin
        code_direct(dv >> 4, fb - 4);
        code_rtree(ALIGN_OFS, 4, dv & 15);
      end
    end
    tstate = (tstate < 7) ? 7 : 10;
  endfunction

  // Note one accepted token and queue the emissions it causes.
  function void note_token(lrc_pkg::tok_in_t t);
    int          before_n;
    int unsigned ps;
    int unsigned len;
    bit [31:0]   d;
    before_n = pending_emissions.size();
    ps = pos & 3;
    case (t.opcode)
      lrc_pkg::OP_LITERAL: begin
        code_bit(MF_OFS + tstate * 4 + ps, 1'b0);
        code_literal(t.literal_byte, t.match_byte, t.prev_byte);
        if (tstate < 4) tstate = 0;
        else if (tstate < 10) tstate = tstate - 3;
        else tstate = tstate - 6;
        pos = (pos + 1) & 3;
      end
      lrc_pkg::OP_MATCH: begin
        len = t.match_length;
        d = t.match_distance;
        if (len < 2) len = 2;
        if (len > 273) len = 273;
        if (d < 1) d = 1;
        if (d > 32'h0080_0000) d = 32'h0080_0000;
        code_match(len, d, ps);
        pos = (pos + len) & 3;
      end
      lrc_pkg::OP_FLUSH: begin
        repeat (5) shift_byte();
      end
      default: ;
    endcase
    if (pending_emissions.size() > before_n)
      pending_emissions[pending_emissions.size() - 1].last = 1'b1;
  endfunction

  // Check one accepted result against the oldest expected emission.
  function void check_result(lrc_pkg::res_t got);
    lrc_pkg::res_t exp_r;
    if (pending_emissions.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: unexpected result %h", got);
      return;
    end
    exp_r = pending_emissions.pop_front();
    if (got.first_byte !== exp_r.first_byte || got.fill_byte !== exp_r.fill_byte ||
        got.fill_count !== exp_r.fill_count || got.last !== exp_r.last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: first %h/%h fill %h/%h count %0d/%0d last %b/%b (exp/act)",
                 exp_r.first_byte, got.first_byte, exp_r.fill_byte, got.fill_byte,
                 exp_r.fill_count, got.fill_count, exp_r.last, got.last);
    end
  endfunction
endclass

module lzma_token_range_encoder_tb;
  import lrc_pkg::*;

  // Opcode the block must drop without effect.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // Cycles without any transfer before the run is declared hung; covers the
  // probability clearing pass after reset with wide margin.
  localparam int STALL_LIMIT = 30000;

  logic     clk_i;
  logic     rst_ni;
  logic     push_i;
  tok_in_t  token_i;
  logic     full_o;
  logic     empty_o;
  logic     pop_i;
  res_t     result_o;

  lzma_emission_sb sb;
  int  idle_cycles;
  bit  burst_mode;
  bit  stim_done;

  lzma_token_range_encoder uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push_i),
    .token_i  (token_i),
    .full_o   (full_o),
    .empty_o  (empty_o),
    .pop_i    (pop_i),
    .result_o (result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Mostly short gaps, a few long ones, none at all in burst stretches.
  function automatic int pick_gap();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Drive one token, hold it until the transfer, then idle a random gap.
  task automatic send_token(tok_in_t t);
    push_i  = 1'b1;
    token_i = t;
    forever begin
      @(posedge clk_i);
      if (!full_o) break;
      @(negedge clk_i);
    end
    sb.note_token(t);
    @(negedge clk_i);
    repeat (pick_gap()) begin
      push_i = 1'b0;
      @(negedge clk_i);
    end
  endtask

  function automatic tok_in_t make_token(logic [1:0] op, logic [7:0] lit, logic [7:0] prev,
                                         logic [7:0] mb, logic [8:0] len,
                                         logic [23:0] distance);
    tok_in_t t;
    t.opcode = op;
    t.literal_byte = lit;
    t.prev_byte = prev;
    t.match_byte = mb;
    t.match_length = len;
    t.match_distance = distance;
    return t;
  endfunction

  // Random token: mostly literals and matches with distances spread over all
  // slots, some matched literals near the match byte, a few flushes and drops.
  function automatic tok_in_t random_token();
    tok_in_t t;
    int r;
    int nbits;
    t = '0;
    t.literal_byte = 8'($urandom);
    t.prev_byte = 8'($urandom);
    t.match_byte = 8'($urandom);
    t.match_length = 9'($urandom);
    t.match_distance = 24'($urandom);
    r = $urandom_range(0, 99);
    if (r < 55) begin
      t.opcode = OP_LITERAL;
      if ($urandom_range(0, 2) == 0)
        t.match_byte = t.literal_byte ^ (8'h01 << $urandom_range(0, 7));
      else if ($urandom_range(0, 4) == 0)
        t.match_byte = t.literal_byte;
    end else if (r < 92) begin
      t.opcode = OP_MATCH;
      r = $urandom_range(0, 9);
      if (r < 6) t.match_length = 9'($urandom_range(2, 17));
      else if (r < 9) t.match_length = 9'($urandom_range(18, 273));
      else t.match_length = 9'($urandom_range(0, 511));
      nbits = $urandom_range(1, 24);
      t.match_distance = 24'($urandom & ((32'd1 << nbits) - 1));
    end else if (r < 97) begin
      t.opcode = OP_FLUSH;
    end else begin
      t.opcode = OP_UNUSED;
    end
    return t;
  endfunction

  // Result side: pop with random stalls, sample at the rising edge.
  initial begin
    int stall;
    pop_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        pop_i = 1'b0;
        stall--;
      end else begin
        pop_i = 1'b1;
        stall = pick_gap();
      end
      @(posedge clk_i);
      if (pop_i && !empty_o) sb.check_result(result_o);
    end
  end

  // Watchdog: end the run when no transfer happens for too long.
  always @(posedge clk_i) begin
    if ((push_i && !full_o) || (pop_i && !empty_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("ERROR: timeout, no transfer for %0d cycles", STALL_LIMIT);
      $display("** lzma_token_range_encoder: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int sent;
    tok_in_t t;
    sb = new();
    idle_cycles = 0;
    burst_mode = 1'b0;
    stim_done = 1'b0;
    push_i = 1'b0;
    token_i = '0;
    rst_ni = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: field extremes, every opcode, clamps, matched literals, flush.
    send_token(make_token(OP_LITERAL, 8'h00, 8'h00, 8'h00, 9'd0, 24'd0));
    send_token(make_token(OP_LITERAL, 8'hFF, 8'hFF, 8'hFF, 9'h1FF, 24'hFFFFFF));
    send_token(make_token(OP_UNUSED, 8'hA5, 8'h5A, 8'h3C, 9'd100, 24'd77));
    send_token(make_token(OP_MATCH, 8'h00, 8'h00, 8'h00, 9'd2, 24'd1));
    send_token(make_token(OP_LITERAL, 8'h5A, 8'hE0, 8'h5A, 9'd2, 24'd1));
    send_token(make_token(OP_MATCH, 8'h00, 8'h00, 8'h00, 9'd273, 24'd2));
    send_token(make_token(OP_LITERAL, 8'h0F, 8'h20, 8'hF0, 9'd2, 24'd1));
    send_token(make_token(OP_MATCH, 8'h00, 8'h00, 8'h00, 9'd0, 24'd0));
    send_token(make_token(OP_MATCH, 8'h00, 8'h00, 8'h00, 9'h1FF, 24'hFFFFFF));
    send_token(make_token(OP_MATCH, 8'h00, 8'h00, 8'h00, 9'd10, 24'h800000));
    send_token(make_token(OP_MATCH, 8'h00, 8'h00, 8'h00, 9'd5, 24'd5));
    send_token(make_token(OP_MATCH, 8'h00, 8'h00, 8'h00, 9'd20, 24'd100));
    send_token(make_token(OP_MATCH, 8'h00, 8'h00, 8'h00, 9'd3, 24'd4));
    send_token(make_token(OP_MATCH, 8'h00, 8'h00, 8'h00, 9'd4, 24'd200));
    send_token(make_token(OP_LITERAL, 8'h80, 8'h7F, 8'h80, 9'd2, 24'd1));
    send_token(make_token(OP_LITERAL, 8'h01, 8'h40, 8'h00, 9'd2, 24'd1));
    send_token(make_token(OP_MATCH, 8'h00, 8'h00, 8'h00, 9'd17, 24'h7FFFFF));
    send_token(make_token(OP_FLUSH, 8'h00, 8'h00, 8'h00, 9'd2, 24'd1));
    send_token(make_token(OP_LITERAL, 8'hC3, 8'hA0, 8'h3C, 9'd2, 24'd1));
    send_token(make_token(OP_FLUSH, 8'hFF, 8'hFF, 8'hFF, 9'h1FF, 24'hFFFFFF));

    // Random part; dropped opcodes do not count.
    sent = 0;
    while (sent < 280) begin
      if (sent % 32 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      t = random_token();
      send_token(t);
      if (t.opcode != OP_UNUSED) sent++;
    end
    burst_mode = 1'b0;
    // Push out the remaining coder bytes.
    send_token(make_token(OP_FLUSH, 8'h00, 8'h00, 8'h00, 9'd2, 24'd1));
    push_i = 1'b0;
    stim_done = 1'b1;

    while (sb.pending_emissions.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_emissions.size() == 0) begin
      $display("** lzma_token_range_encoder: PASSED **");
    end else begin
      $display("** lzma_token_range_encoder: FAILED **");
    end
    $finish;
  end
endmodule

`default_nettype wire
